// ===== rtl/reservation_station_execute_top_macros.svh =====
// Assertion macros for the reservation station execute block.
`ifndef RESERVATION_STATION_EXECUTE_TOP_MACROS_SVH
`define RESERVATION_STATION_EXECUTE_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RSE_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RSE_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/rse_pkg.sv =====
// Shared types and constants for the reservation station execute block.
package rse_pkg;

  localparam int DEF_NUM_STATIONS = 8;

  localparam logic [3:0] RST_ISSUE_LAT = 4'd1;
  localparam logic [5:0] RST_ADD_LAT   = 6'd4;
  localparam logic [5:0] RST_MULT_LAT  = 6'd12;
  localparam logic [5:0] RST_DIV_LAT   = 6'd38;

  localparam logic [1:0] CFG_ISSUE_LAT = 2'd0;
  localparam logic [1:0] CFG_ADD_LAT   = 2'd1;
  localparam logic [1:0] CFG_MULT_LAT  = 2'd2;
  localparam logic [1:0] CFG_DIV_LAT   = 2'd3;

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_MULT = 2'd2;
  localparam logic [1:0] OP_DIV  = 2'd3;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_ISSUE   = 2'd1,
    CMD_SUPPLY  = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_FLUSH
  } back_state_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        in_range;
    logic [2:0]  station;
    logic [1:0]  operation;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic        first_ready;
    logic        second_ready;
    logic [9:0]  instr_number;
    logic        operand_side;
    logic [31:0] cycle_now;
  } cmd_t;

  typedef struct packed {
    logic idle;
    logic scanning;
    logic in_div;
  } bk_status_t;

endpackage

// ===== rtl/rse_front.sv =====
// Front end: accepts command words, classifies them and queues them for the back end.
module rse_front
  import rse_pkg::*;
#(
  parameter int NUM_STATIONS = DEF_NUM_STATIONS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [2:0]  station,
  input  logic [1:0]  operation,
  input  logic [31:0] first_value,
  input  logic [31:0] second_value,
  input  logic        first_ready,
  input  logic        second_ready,
  input  logic [9:0]  instr_number,
  input  logic        operand_side,
  input  logic [31:0] cycle_now,
  output cmd_t        head,
  output logic        head_valid,
  input  logic        pop
);

  cmd_t        entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  cmd_t        incoming;
  logic        push;

  always_comb begin
    incoming.kind         = cmd_kind_t'(opcode);
    incoming.in_range     = (32'(station) < NUM_STATIONS);
    incoming.station      = station;
    incoming.operation    = operation;
    incoming.first_value  = first_value;
    incoming.second_value = second_value;
    incoming.first_ready  = first_ready;
    incoming.second_ready = second_ready;
    incoming.instr_number = instr_number;
    incoming.operand_side = operand_side;
    incoming.cycle_now    = cycle_now;
  end

  assign in_ready   = (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= incoming;
  end

endmodule

// ===== rtl/rse_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module rse_div
  import rse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy;
  logic [4:0]  step;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [33:0] trial;

  assign trial    = {1'b0, rem, quo[31]} - {2'b00, dvs};
  assign quotient = neg ? (32'd0 - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 5'd31;
      end else if (busy) begin
        step <= step - 5'd1;
        if (step == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs <= divisor[31] ? (32'd0 - divisor) : divisor;
      rem <= 32'd0;
      neg <= dividend[31] ^ divisor[31];
    end else if (busy) begin
      if (!trial[33]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/rse_back.sv =====
// Back end: station bank, tick scan sequencer, shared multiply and divide, result register.
module rse_back
  import rse_pkg::*;
#(
  parameter int NUM_STATIONS = DEF_NUM_STATIONS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  station_index,
  output logic [9:0]  instr_tag,
  output logic        began,
  output logic        finished,
  output logic [31:0] result_value,
  output logic        divide_by_zero,
  output logic [31:0] event_cycle,
  output logic        last,
  output bk_status_t  status
);

  localparam int IW = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] IDX_END = CW'(NUM_STATIONS);

  logic [3:0] issue_latency;
  logic [5:0] add_latency;
  logic [5:0] mult_latency;
  logic [5:0] div_latency;

  logic        busy           [NUM_STATIONS];
  logic [3:0]  issue_wait     [NUM_STATIONS];
  logic [5:0]  exec_count     [NUM_STATIONS];
  logic [1:0]  op_kind        [NUM_STATIONS];
  logic [31:0] first_operand  [NUM_STATIONS];
  logic [31:0] second_operand [NUM_STATIONS];
  logic        first_valid    [NUM_STATIONS];
  logic        second_valid   [NUM_STATIONS];
  logic [9:0]  instr_id       [NUM_STATIONS];
  logic        begun          [NUM_STATIONS];

  back_state_t state;
  back_state_t state_next;
  logic [CW-1:0] idx;
  logic [31:0] tick_cycle;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  logic        ev_valid;
  logic [2:0]  ev_station;
  logic [9:0]  ev_tag;
  logic        ev_began;
  logic        ev_finished;
  logic [31:0] ev_result;
  logic        ev_dz;

  logic [IW-1:0] s;
  logic [IW-1:0] ci;
  logic          scan_end;
  logic          out_free;
  logic          wait_match;
  logic          active;
  logic [5:0]    cnt_inc;
  logic [5:0]    lat;
  logic          s_fin;
  logic          s_event;
  logic          can_go;
  logic          scan_step;
  logic          ev_here;
  logic          fin_mul;
  logic          fin_div;
  logic          flush_push;
  logic          push_ev;
  logic          cmd_write;
  logic [31:0]   imm_result;
  logic          imm_dz;
  logic          div_done;
  logic [31:0]   div_q;

  assign s        = idx[IW-1:0];
  assign ci       = IW'(cmd.station);
  assign scan_end = (idx == IDX_END);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    wait_match = (issue_wait[s] == issue_latency);
    active     = busy[s] && wait_match && first_valid[s] && second_valid[s];
    cnt_inc    = exec_count[s] + 6'd1;
    case (op_kind[s])
      OP_ADD, OP_SUB: lat = add_latency;
      OP_MULT:        lat = mult_latency;
      default:        lat = div_latency;
    endcase
    s_fin   = (cnt_inc == lat);
    s_event = s_fin || !begun[s];
    imm_dz  = 1'b0;
    case (op_kind[s])
      OP_ADD:  imm_result = first_operand[s] + second_operand[s];
      OP_SUB:  imm_result = first_operand[s] - second_operand[s];
      OP_MULT: imm_result = 32'd0;
      default: begin
        imm_result = 32'd0;
        imm_dz     = (second_operand[s] == 32'd0);
      end
    endcase
  end

  always_comb begin
    pop        = (state == ST_IDLE) && cmd_valid;
    cmd_write  = pop && cmd.in_range;
    can_go     = !(active && s_event && ev_valid && !out_free);
    scan_step  = (state == ST_SCAN) && !scan_end && can_go;
    ev_here    = scan_step && active && s_event;
    fin_mul    = ev_here && s_fin && (op_kind[s] == OP_MULT);
    fin_div    = ev_here && s_fin && (op_kind[s] == OP_DIV) &&
                 (second_operand[s] != 32'd0);
    flush_push = (state == ST_FLUSH) && ev_valid && out_free;
    push_ev    = (ev_here && ev_valid) || flush_push;
    status.idle     = (state == ST_IDLE);
    status.scanning = (state == ST_SCAN);
    status.in_div   = (state == ST_DIV);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_TICK) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_next = ST_FLUSH;
        else if (fin_mul) state_next = ST_MUL;
        else if (fin_div) state_next = ST_DIV;
      end
      ST_MUL: state_next = ST_SCAN;
      ST_DIV: begin
        if (div_done) state_next = ST_SCAN;
      end
      ST_FLUSH: begin
        if (!ev_valid || out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  rse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (fin_div),
    .dividend (first_operand[s]),
    .divisor  (second_operand[s]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_latency <= RST_ISSUE_LAT;
      add_latency   <= RST_ADD_LAT;
      mult_latency  <= RST_MULT_LAT;
      div_latency   <= RST_DIV_LAT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ISSUE_LAT: issue_latency <= cfg_data[3:0];
        CFG_ADD_LAT:   add_latency   <= cfg_data;
        CFG_MULT_LAT:  mult_latency  <= cfg_data;
        CFG_DIV_LAT:   div_latency   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STATIONS; i++) begin
        busy[i]         <= 1'b0;
        issue_wait[i]   <= 4'd0;
        exec_count[i]   <= 6'd0;
        first_valid[i]  <= 1'b0;
        second_valid[i] <= 1'b0;
        begun[i]        <= 1'b0;
      end
    end else begin
      if (cmd_write) begin
        case (cmd.kind)
          CMD_ISSUE: begin
            busy[ci]         <= 1'b1;
            first_valid[ci]  <= cmd.first_ready;
            second_valid[ci] <= cmd.second_ready;
            issue_wait[ci]   <= 4'd0;
            exec_count[ci]   <= 6'd0;
            begun[ci]        <= 1'b0;
          end
          CMD_SUPPLY: begin
            if (cmd.operand_side) second_valid[ci] <= 1'b1;
            else first_valid[ci] <= 1'b1;
          end
          CMD_RELEASE: begin
            busy[ci]         <= 1'b0;
            first_valid[ci]  <= 1'b0;
            second_valid[ci] <= 1'b0;
            issue_wait[ci]   <= 4'd0;
            exec_count[ci]   <= 6'd0;
            begun[ci]        <= 1'b0;
          end
          default: ;
        endcase
      end
      if (scan_step && busy[s]) begin
        if (!wait_match) begin
          issue_wait[s] <= issue_wait[s] + 4'd1;
        end else if (active) begin
          begun[s] <= 1'b1;
          if (s_fin) begin
            exec_count[s] <= 6'd0;
            issue_wait[s] <= 4'd0;
          end else begin
            exec_count[s] <= cnt_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_write) begin
      case (cmd.kind)
        CMD_ISSUE: begin
          op_kind[ci]        <= cmd.operation;
          first_operand[ci]  <= cmd.first_value;
          second_operand[ci] <= cmd.second_value;
          instr_id[ci]       <= cmd.instr_number;
        end
        CMD_SUPPLY: begin
          if (cmd.operand_side) second_operand[ci] <= cmd.first_value;
          else first_operand[ci] <= cmd.first_value;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      ev_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && cmd.kind == CMD_TICK) idx <= '0;
      else if (scan_step) idx <= idx + CW'(1);
      if (ev_here) ev_valid <= !(fin_mul || fin_div);
      else if ((state == ST_MUL) || (state == ST_DIV && div_done)) ev_valid <= 1'b1;
      else if (flush_push) ev_valid <= 1'b0;
      if (push_ev) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cmd.kind == CMD_TICK) tick_cycle <= cmd.cycle_now;
    if (fin_mul) begin
      mul_a <= first_operand[s];
      mul_b <= second_operand[s];
    end
    if (ev_here) begin
      ev_station  <= 3'(s);
      ev_tag      <= instr_id[s];
      ev_began    <= !begun[s];
      ev_finished <= s_fin;
      ev_result   <= s_fin ? imm_result : 32'd0;
      ev_dz       <= s_fin && imm_dz;
    end else if (state == ST_MUL) begin
      ev_result <= mul_a * mul_b;
    end else if (state == ST_DIV && div_done) begin
      ev_result <= div_q;
    end
    if (push_ev) begin
      station_index  <= ev_station;
      instr_tag      <= ev_tag;
      began          <= ev_began;
      finished       <= ev_finished;
      result_value   <= ev_result;
      divide_by_zero <= ev_dz;
      event_cycle    <= tick_cycle;
      last           <= (state == ST_FLUSH);
    end
  end

endmodule

// ===== rtl/reservation_station_execute_top.sv =====
// A non-tick word goes into the input queue and then into its station's registers when the idle back end pops it.
// A tick word scans every station in turn and then flushes its pending event; each finishing
// multiply adds a multiply state, each finishing divide waits for the divider, and result stalls hold the scan.
// The scan sequencer and the shared divider set the rate; a two-word queue buffers input.
// Reset is synchronous and active high; it frees all stations and restores the latencies.
module reservation_station_execute_top
  import rse_pkg::*;
#(
  parameter int NUM_STATIONS = DEF_NUM_STATIONS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [2:0]  station,
  input  logic [1:0]  operation,
  input  logic signed [31:0] first_value,
  input  logic signed [31:0] second_value,
  input  logic        first_ready,
  input  logic        second_ready,
  input  logic [9:0]  instr_number,
  input  logic        operand_side,
  input  logic [31:0] cycle_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  station_index,
  output logic [9:0]  instr_tag,
  output logic        began,
  output logic        finished,
  output logic signed [31:0] result_value,
  output logic        divide_by_zero,
  output logic [31:0] event_cycle,
  output logic        last
);

`include "reservation_station_execute_top_macros.svh"

  cmd_t       cmd_head;
  logic       cmd_valid;
  logic       cmd_pop;
  bk_status_t bk_status;
  logic       tick_pop;

  assign tick_pop = cmd_pop && (cmd_head.kind == CMD_TICK);

  rse_front #(.NUM_STATIONS(NUM_STATIONS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .station      (station),
    .operation    (operation),
    .first_value  (first_value),
    .second_value (second_value),
    .first_ready  (first_ready),
    .second_ready (second_ready),
    .instr_number (instr_number),
    .operand_side (operand_side),
    .cycle_now    (cycle_now),
    .head         (cmd_head),
    .head_valid   (cmd_valid),
    .pop          (cmd_pop)
  );

  rse_back #(.NUM_STATIONS(NUM_STATIONS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd_head),
    .cmd_valid      (cmd_valid),
    .pop            (cmd_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .station_index  (station_index),
    .instr_tag      (instr_tag),
    .began          (began),
    .finished       (finished),
    .result_value   (result_value),
    .divide_by_zero (divide_by_zero),
    .event_cycle    (event_cycle),
    .last           (last),
    .status         (bk_status)
  );

  `RSE_ASSERT_IMP(a_no_pop_while_dividing, bk_status.in_div, !cmd_pop, "word taken during divide")
  `RSE_ASSERT_IMP(a_pop_only_when_idle, cmd_pop, bk_status.idle, "word taken outside idle")
  `RSE_ASSERT_NXT(a_tick_starts_scan, tick_pop, bk_status.scanning, "tick did not start a scan")

endmodule
